// ----- hw/rtl/lru_key_value_store_macros.svh -----
// Assertion macros shared by the LRU key/value store RTL.
`ifndef LRU_KEY_VALUE_STORE_MACROS_SVH
`define LRU_KEY_VALUE_STORE_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define LKV_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru_key_value_store: same-cycle check failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define LKV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru_key_value_store: next-cycle check failed");

`endif

// ----- hw/rtl/lkv_pkg.sv -----
// Shared types and sizes for the LRU key/value store.
package lkv_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	// Operation codes carried in the input tuser field.
	typedef enum logic [1:0] {
		OP_FIND = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	// One table entry as held by a cell.
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                exec;
		op_t                 op;
		logic [KEY_BITS-1:0] key;
		logic                any_hit;
		logic                grow;
	} cell_ctrl_t;

endpackage

// ----- hw/rtl/lkv_cell.sv -----
// One cell of the recency chain: holds one entry and shifts it toward the older end.
module lkv_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lkv_pkg::cell_ctrl_t ctrl,
	input  lkv_pkg::entry_t     prev,
	input  logic                ge_in,
	input  logic                next_valid,
	output lkv_pkg::entry_t     entry,
	output logic                hit,
	output logic                ge_out,
	output logic                lru
);
	import lkv_pkg::*;

	logic                  valid_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  shift;
	logic                  drop;

	// Key match for lookups; the chain of ge flags tells whether a hit sits here or older.
	always_comb begin
		hit    = valid_q && (key_q == ctrl.key) &&
			(ctrl.op == OP_FIND || ctrl.op == OP_PUSH);
		ge_out = ge_in | hit;
		lru    = valid_q & ~next_valid;
	end

	// A hit at this cell or an older one, or an insert, moves the newer neighbor in.
	always_comb begin
		shift = ctrl.exec & ((ctrl.any_hit & ge_out) | ctrl.grow);
		drop  = ctrl.exec & (ctrl.op == OP_POP) & lru;
	end

	// Valid bit is control state and is cleared by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev.valid;
		end else if (drop) begin
			valid_q <= 1'b0;
		end
	end

	// Key and value follow the shift and need no reset.
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= prev.key;
			value_q <= prev.value;
		end
	end

	always_comb begin
		entry.valid = valid_q;
		entry.key   = key_q;
		entry.value = value_q;
	end

endmodule

// ----- hw/rtl/lru_key_value_store.sv -----
// Top level of the LRU key/value store: command register, cell chain and result register.
//
//   channel   dir   tdata                          tuser
//   s_*       in    key [31:0], value_in [63:32]   mode [1:0]
//   m_*       out   value_out [31:0]               hit [0], overflow [1]
//
// An accepted word is held in the command register and is executed once the result
// register is free or being drained; the result then goes into the result register.
// The single command register takes no new word until its word has executed. The
// cells are kept in recency order, most recent at cell 0, so a find or push is one
// parallel compare and at most one shift; a pop clears the oldest entry. Reset clears
// the valid bits of all cells at once. A stalled result holds the command register.
module lru_key_value_store (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // key [31:0], value_in [63:32]
	input  logic [1:0]  s_tuser,   // mode [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // value_out [31:0]
	output logic [1:0]  m_tuser    // hit [0], overflow [1]
);
	import lkv_pkg::*;

	logic                  busy_q;
	op_t                   cmd_op_q;
	logic [KEY_BITS-1:0]   cmd_key_q;
	logic [VALUE_BITS-1:0] cmd_value_q;

	logic                  out_valid_q;
	logic                  out_hit_q;
	logic                  out_ovf_q;
	logic [31:0]           out_value_q;

	logic                  exec;
	logic                  take_in;
	cell_ctrl_t            ctrl;
	entry_t                head;
	entry_t                cell_entry [CAPACITY];
	logic [CAPACITY-1:0]   hit_vec;
	logic [CAPACITY-1:0]   lru_vec;
	logic [CAPACITY-1:0]   valid_vec;
	logic [CAPACITY:0]     ge_chain;
	logic [VALUE_BITS-1:0] hit_value;
	logic [VALUE_BITS-1:0] lru_value;
	logic                  any_hit;
	logic                  any_lru;
	logic                  full;
	logic                  is_lookup;
	logic                  res_hit;
	logic                  res_ovf;
	logic [VALUE_BITS-1:0] res_value;

	// Handshake: one word in the command register at a time.
	assign s_tready = ~busy_q;
	assign take_in  = s_tvalid & ~busy_q;
	assign exec     = busy_q & (~out_valid_q | m_tready);

	// Command register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (take_in) begin
			busy_q <= 1'b1;
		end else if (exec) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_op_q    <= op_t'(s_tuser);
			cmd_key_q   <= KEY_BITS'(s_tdata[31:0]);
			cmd_value_q <= VALUE_BITS'(s_tdata[63:32]);
		end
	end

	// Reductions over the chain: hit and oldest-entry values, table fill.
	always_comb begin
		hit_value = '0;
		lru_value = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			hit_value = hit_value | (cell_entry[i].value & {VALUE_BITS{hit_vec[i]}});
			lru_value = lru_value | (cell_entry[i].value & {VALUE_BITS{lru_vec[i]}});
			valid_vec[i] = cell_entry[i].valid;
		end
		any_hit   = |hit_vec;
		any_lru   = |lru_vec;
		full      = cell_entry[CAPACITY-1].valid;
		is_lookup = (cmd_op_q == OP_FIND) || (cmd_op_q == OP_PUSH);
	end

	// Command broadcast and the entry that enters cell 0 on a shift.
	always_comb begin
		ctrl.exec    = exec;
		ctrl.op      = cmd_op_q;
		ctrl.key     = cmd_key_q;
		ctrl.any_hit = any_hit;
		ctrl.grow    = exec & (cmd_op_q == OP_PUSH) & ~any_hit & ~full;
		head.valid   = 1'b1;
		head.key     = cmd_key_q;
		head.value   = (cmd_op_q == OP_PUSH) ? cmd_value_q : hit_value;
	end

	assign ge_chain[CAPACITY] = 1'b0;

	// The chain of cells, most recent entry at cell 0.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		entry_t prev_entry;
		logic   nxt_valid;

		if (g == 0) begin : g_head
			assign prev_entry = head;
		end else begin : g_body
			assign prev_entry = cell_entry[g-1];
		end

		if (g == CAPACITY - 1) begin : g_tail
			assign nxt_valid = 1'b0;
		end else begin : g_mid
			assign nxt_valid = cell_entry[g+1].valid;
		end

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev       (prev_entry),
			.ge_in      (ge_chain[g+1]),
			.next_valid (nxt_valid),
			.entry      (cell_entry[g]),
			.hit        (hit_vec[g]),
			.ge_out     (ge_chain[g]),
			.lru        (lru_vec[g])
		);
	end

	// Result of the executed command.
	always_comb begin
		res_hit   = 1'b0;
		res_ovf   = 1'b0;
		res_value = '0;
		if (is_lookup && any_hit) begin
			res_hit   = 1'b1;
			res_value = hit_value;
		end else if (cmd_op_q == OP_POP && any_lru) begin
			res_hit   = 1'b1;
			res_value = lru_value;
		end
		if (cmd_op_q == OP_PUSH && !any_hit && full) begin
			res_ovf = 1'b1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec) begin
			out_hit_q   <= res_hit;
			out_ovf_q   <= res_ovf;
			out_value_q <= 32'(res_value);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_value_q;
	assign m_tuser  = {out_ovf_q, out_hit_q};

`include "lru_key_value_store_macros.svh"

	// A key is stored at most once.
	`LKV_ASSERT_SAME(a_key_unique, busy_q, $onehot0(hit_vec))
	// Valid entries stay packed toward the most recent end of the chain.
	`LKV_ASSERT_SAME(a_packed, 1'b1, (valid_vec & CAPACITY'(valid_vec + 1'b1)) == '0)
	// A result never reports both a hit and an overflow.
	`LKV_ASSERT_SAME(a_hit_ovf, out_valid_q, !(out_hit_q && out_ovf_q))
	// Every executed command leaves a result and frees the command register.
	`LKV_ASSERT_NEXT(a_exec_result, exec, out_valid_q && !busy_q)

endmodule

// ----- bench/tb_lru_key_value_store.sv -----
// Self-checking testbench for the LRU key/value store with a recency-list predictor.
module tb_lru_key_value_store;
	import lkv_pkg::*;

	// One word for the command stream; a drain entry holds the sender until all results are back.
	typedef struct packed {
		logic                  drain;
		op_t                   op;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value_in;
	} command_t;

	// Fields of one result word.
	typedef struct packed {
		logic                  hit;
		logic [VALUE_BITS-1:0] value_out;
		logic                  overflow;
	} result_t;

	// One live table entry as tracked by the predictor.
	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} stored_t;

	localparam int POOL_SIZE = 24;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;   // key [31:0], value_in [63:32]
	logic [1:0]  s_tuser = '0;   // mode [1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // value_out [31:0]
	logic [1:0]  m_tuser;        // hit [0], overflow [1]

	command_t            command_queue[$];
	command_t            on_bus;
	result_t             pending_results[$];
	result_t             got;
	result_t             want;
	stored_t             recency_list[$];
	logic [KEY_BITS-1:0] key_pool[POOL_SIZE];
	int                  words_sent = 0;
	int                  results_seen = 0;
	int                  fail_count = 0;
	logic                send_now;

	lru_key_value_store dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Applies one command to the recency list (most recent first) and returns its result.
	function automatic result_t apply_command(op_t op, logic [KEY_BITS-1:0] k,
			logic [VALUE_BITS-1:0] v);
		result_t r;
		stored_t e;
		int      idx;
		r = '0;
		idx = -1;
		foreach (recency_list[i]) begin
			if (idx < 0 && recency_list[i].key == k)
				idx = i;
		end
		case (op)
			OP_FIND: begin
				if (idx >= 0) begin
					e = recency_list[idx];
					r.hit = 1'b1;
					r.value_out = e.value;
					recency_list.delete(idx);
					recency_list.push_front(e);
				end
			end
			OP_PUSH: begin
				if (idx >= 0) begin
					e = recency_list[idx];
					r.hit = 1'b1;
					r.value_out = e.value;
					e.value = v;
					recency_list.delete(idx);
					recency_list.push_front(e);
				end else if (recency_list.size() >= CAPACITY) begin
					// A new key with no room left changes nothing.
					r.overflow = 1'b1;
				end else begin
					e.key = k;
					e.value = v;
					recency_list.push_front(e);
				end
			end
			OP_POP: begin
				if (recency_list.size() > 0) begin
					e = recency_list.pop_back();
					r.hit = 1'b1;
					r.value_out = e.value;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic add_word(op_t op, logic [KEY_BITS-1:0] k, logic [VALUE_BITS-1:0] v);
		command_t c;
		c.drain = 1'b0;
		c.op = op;
		c.key = k;
		c.value_in = v;
		command_queue.push_back(c);
	endtask

	task automatic add_drain();
		command_t c;
		c = '0;
		c.drain = 1'b1;
		command_queue.push_back(c);
	endtask

	// Sender: presents queued words, idles at random outside a calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(apply_command(on_bus.op, on_bus.key, on_bus.value_in));
				words_sent++;
			end
			if (!s_tvalid || s_tready) begin
				send_now = 1'b0;
				if (command_queue.size() > 0 && command_queue[0].drain) begin
					// Hold off until every outstanding result has been checked.
					if (pending_results.size() == 0)
						void'(command_queue.pop_front());
				end else if (command_queue.size() > 0) begin
					send_now = (words_sent >= 500 && words_sent < 700) ||
						$urandom_range(99) >= 37;
				end
				if (send_now) begin
					on_bus = command_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {on_bus.value_in, on_bus.key};
					s_tuser <= on_bus.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result word against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				got.hit = m_tuser[0];
				got.overflow = m_tuser[1];
				got.value_out = m_tdata;
				if (pending_results.size() == 0) begin
					$error("unexpected result word: hit %0d value_out %h overflow %0d",
						got.hit, got.value_out, got.overflow);
					fail_count++;
				end else begin
					want = pending_results.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						fail_count++;
					end
					if (got.value_out !== want.value_out) begin
						$error("value_out: expected %h, got %h", want.value_out, got.value_out);
						fail_count++;
					end
					if (got.overflow !== want.overflow) begin
						$error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
						fail_count++;
					end
				end
			end
			m_tready <= (results_seen >= 450 && results_seen < 700) ||
				$urandom_range(99) >= 37;
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int   kind;
		int   roll;
		op_t  op;
		logic [KEY_BITS-1:0] k;

		// Directed part: empty table, extreme keys and values, replace, fill, overflow.
		add_word(OP_POP, 32'h0, 32'h0);
		add_word(OP_FIND, 32'h0, 32'hFFFF_FFFF);
		add_word(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_PUSH, 32'h0, 32'h0);
		add_word(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_word(OP_FIND, 32'h0, 32'h0);
		add_word(OP_FIND, 32'hFFFF_FFFF, 32'h0);
		add_word(OP_PUSH, 32'h0, 32'hA5A5_A5A5);
		add_word(OP_FIND, 32'h1234_5678, 32'h0);
		for (int i = 1; i <= CAPACITY - 2; i++)
			add_word(OP_PUSH, 32'h8000_0000 | i, $urandom);
		add_word(OP_PUSH, 32'h0000_0100, 32'h1111_1111);
		add_word(OP_PUSH, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
		add_word(OP_POP, $urandom, $urandom);
		add_word(OP_POP, $urandom, $urandom);
		add_drain();

		// Key pool larger than the table so hits, misses and overflows all occur.
		key_pool[0] = 32'h0;
		key_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		// Random part in phases that grow, churn and shrink the table.
		for (int n = 0; n < 1200; n++) begin
			if (n == 600)
				add_drain();
			kind = (n / 100) % 3;
			roll = $urandom_range(99);
			if (roll < 3)
				op = OP_NONE;
			else if (kind == 0)
				op = roll < 60 ? OP_PUSH : (roll < 90 ? OP_FIND : OP_POP);
			else if (kind == 1)
				op = roll < 40 ? OP_PUSH : (roll < 75 ? OP_FIND : OP_POP);
			else
				op = roll < 25 ? OP_PUSH : (roll < 55 ? OP_FIND : OP_POP);
			k = $urandom_range(99) < 85 ? key_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
			add_word(op, k, $urandom);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (command_queue.size() > 0 || s_tvalid)
			@(posedge clk);
		while (pending_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
